/* design/calibrated_time_of_day_clock_core_macros.svh */
// Assertion macros shared by the clock core
`ifndef CALIBRATED_TIME_OF_DAY_CLOCK_CORE_MACROS_SVH
`define CALIBRATED_TIME_OF_DAY_CLOCK_CORE_MACROS_SVH

// implication checked every cycle outside reset
`define CTC_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("check failed");

// implication checked in the cycle after the antecedent
`define CTC_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("check failed");

`endif

/* design/ctodc_pkg.sv */
package ctodc_pkg;

    localparam int unsigned MS_PER_S     = 1000;
    localparam int unsigned SEC_PER_MIN  = 60;
    localparam int unsigned SEC_PER_HOUR = 3600;
    localparam int unsigned SEC_PER_DAY  = 86400;
    localparam int unsigned NOW_W        = 48;

    // reciprocals for exact floor division of bounded operands
    localparam logic [26:0] MS_RECIP   = 27'd68719477;  // 2^36 / 1000, 26-bit operand
    localparam logic [25:0] DAY_RECIP  = 26'd50903317;  // 2^35 / 675, 25-bit operand
    localparam logic [13:0] HOUR_RECIP = 14'd9321;      // 2^21 / 225, 13-bit operand
    localparam logic [10:0] MIN_RECIP  = 11'd1093;      // 2^14 / 15, 10-bit operand

    typedef enum logic [8:0] {
        ST_IDLE  = 9'b000000001,
        ST_DIV   = 9'b000000010,
        ST_MUL   = 9'b000000100,
        ST_OFS   = 9'b000001000,
        ST_TMS   = 9'b000010000,
        ST_SEC   = 9'b000100000,
        ST_DAY   = 9'b001000000,
        ST_HMS   = 9'b010000000,
        ST_OUT   = 9'b100000000
    } ctodc_state_t;

    // controller -> datapath
    typedef struct packed {
        logic load;      // capture input beat
        logic div_start;
        logic div_step;
        logic mul_start;
        logic mul_step;
        logic ofs_upd;   // sync bookkeeping
        logic tms_calc;
        logic sec_step;
        logic day_calc;
        logic hms_calc;
        logic out_load;  // result into output register
    } ctodc_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic is_sync;
        logic div_needed;
        logic div_done;
        logic mul_done;
        logic sec_done;
        logic fold_done;
    } ctodc_sts_t;

endpackage

/* design/ctodc_ctrl.sv */
module ctodc_ctrl
    import ctodc_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    output logic       m_tvalid,
    input  logic       m_tready,
    input  ctodc_sts_t sts,
    output ctodc_cmd_t cmd
);
    `include "calibrated_time_of_day_clock_core_macros.svh"

    ctodc_state_t state_reg, state_next;
    logic         sync_reg, sync_next;
    logic         mvalid_reg, mvalid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            sync_reg   <= 1'b0;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            sync_reg   <= sync_next;
            mvalid_reg <= mvalid_next;
        end
    end

    // output register decouples the result beat from the next input beat
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = mvalid_reg;

    always_comb begin
        state_next  = state_reg;
        sync_next   = sync_reg;
        mvalid_next = mvalid_reg;
        cmd         = '0;
        if (mvalid_reg && m_tready) begin
            mvalid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                // first cycle after load: decide on the sync path
                if (sts.is_sync && sts.div_needed && !sync_reg) begin
                    cmd.div_start = 1'b1;
                    sync_next     = 1'b1;
                end else if (sync_reg && !sts.div_done) begin
                    cmd.div_step = 1'b1;
                end else begin
                    sync_next     = 1'b0;
                    cmd.mul_start = 1'b1;
                    state_next    = ST_MUL;
                end
            end
            ST_MUL: begin
                if (sts.mul_done) begin
                    state_next = sts.is_sync ? ST_OFS : ST_TMS;
                end else begin
                    cmd.mul_step = 1'b1;
                end
            end
            ST_OFS: begin
                cmd.ofs_upd = 1'b1;
                state_next  = ST_TMS;
            end
            ST_TMS: begin
                cmd.tms_calc = 1'b1;
                state_next   = ST_SEC;
            end
            ST_SEC: begin
                if (sts.sec_done) begin
                    state_next = ST_DAY;
                end else begin
                    cmd.sec_step = 1'b1;
                end
            end
            ST_DAY: begin
                if (sts.fold_done) begin
                    state_next = ST_HMS;
                end else begin
                    cmd.day_calc = 1'b1;
                end
            end
            ST_HMS: begin
                cmd.hms_calc = 1'b1;
                state_next   = ST_OUT;
            end
            ST_OUT: begin
                // wait here while the previous beat is still held
                if (!mvalid_reg || m_tready) begin
                    cmd.out_load = 1'b1;
                    mvalid_next  = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    `CTC_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid)
    `CTC_ASSERT_NEXT(a_load_starts, aclk, aresetn, s_tvalid && s_tready, state_reg == ST_DIV)
    `CTC_ASSERT_IMP(a_onehot_state, aclk, aresetn, 1'b1, $onehot(state_reg))

endmodule

/* design/ctodc_dp.sv */
module ctodc_dp
    import ctodc_pkg::*;
#(
    parameter int unsigned FRAC_BITS = 32
)(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         in_kind,
    input  logic [47:0]  in_now_ms,
    input  ctodc_cmd_t   cmd,
    output ctodc_sts_t   sts,
    output logic [31:0]  time_s,
    output logic [4:0]   hours,
    output logic [5:0]   minutes,
    output logic [5:0]   seconds
);
    `include "calibrated_time_of_day_clock_core_macros.svh"

    localparam int unsigned DIV_STEPS = 128;
    localparam int unsigned SEC_STEPS = 8;

    // architectural state
    logic [63:0] tick_reg, last_ticks_reg, rate_reg, offset_reg;
    logic [47:0] last_ms_reg;
    // per beat
    logic        kind_reg;
    logic [47:0] now_reg;
    // rate divider (restoring, one bit a cycle)
    logic [127:0] dnum_reg;
    logic [63:0]  drem_reg, dq_reg, dden_reg;
    logic [7:0]   dcnt_reg;
    logic         dbusy_reg;
    // multiplier: 64x64 via 32x32 partial products, one per cycle
    logic [127:0] macc_reg;
    logic [2:0]   mcnt_reg;
    // ms -> s: 16-bit digits, reciprocal multiply then remainder
    logic [63:0]  smag_reg;
    logic [31:0]  sq_reg;
    logic [51:0]  sprod_reg;
    logic [9:0]   srem_reg;
    logic [3:0]   scnt_reg;
    logic         sneg_reg;
    // day fold by reciprocal multiplies
    logic [50:0]  fprod_reg;
    logic [2:0]   fcnt_reg;
    logic [16:0]  day_reg;
    logic [11:0]  rhr_reg;
    logic [31:0]  ts_reg;
    logic [4:0]   hours_reg;
    logic [5:0]   min_reg, sec_reg;
    // output register
    logic [31:0]  out_ts_reg;
    logic [4:0]   out_hours_reg;
    logic [5:0]   out_min_reg, out_sec_reg;

    logic [63:0] el_ticks;
    logic [47:0] el_ms;
    assign el_ticks = tick_reg - last_ticks_reg;
    assign el_ms    = now_reg - last_ms_reg;

    logic [64:0] dtrial;
    logic        dtop;
    always_comb begin
        dtop   = drem_reg[63];
        dtrial = {drem_reg, dnum_reg[127]} - {1'b0, dden_reg};
    end

    logic [31:0] ma, mb;
    logic [63:0] mprod;
    always_comb begin
        ma = mcnt_reg[1] ? tick_reg[63:32] : tick_reg[31:0];
        mb = mcnt_reg[0] ? rate_reg[63:32] : rate_reg[31:0];
        mprod = {32'd0, ma} * {32'd0, mb};
    end

    logic [63:0] scaled;
    assign scaled = macc_reg[FRAC_BITS +: 64];

    // partial dividend below 1000 * 2^16
    logic [25:0] sv;
    logic [15:0] sqd;
    assign sv  = {srem_reg, smag_reg[63:48]};
    assign sqd = sprod_reg[51:36];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_reg       <= '0;
            last_ticks_reg <= '0;
            last_ms_reg    <= '0;
            rate_reg       <= '0;
            offset_reg     <= '0;
            dbusy_reg      <= 1'b0;
            dcnt_reg       <= '0;
            mcnt_reg       <= '0;
            scnt_reg       <= '0;
            fcnt_reg       <= '0;
            out_ts_reg     <= '0;
            out_hours_reg  <= '0;
            out_min_reg    <= '0;
            out_sec_reg    <= '0;
        end else begin
            if (cmd.load) begin
                kind_reg <= in_kind;
                now_reg  <= in_now_ms;
                if (!in_kind) tick_reg <= tick_reg + 64'd1;
            end
            if (cmd.div_start) begin
                dnum_reg  <= {64'd0, el_ms, 16'd0} << (FRAC_BITS - 16);
                dden_reg  <= el_ticks;
                drem_reg  <= '0;
                dq_reg    <= '0;
                dcnt_reg  <= '0;
                dbusy_reg <= 1'b1;
            end else if (cmd.div_step) begin
                dnum_reg <= dnum_reg << 1;
                if (dtop || !dtrial[64]) begin
                    drem_reg <= dtrial[63:0];
                    dq_reg   <= {dq_reg[62:0], 1'b1};
                end else begin
                    drem_reg <= {drem_reg[62:0], dnum_reg[127]};
                    dq_reg   <= {dq_reg[62:0], 1'b0};
                end
                dcnt_reg <= dcnt_reg + 8'd1;
                if (dcnt_reg == 8'(DIV_STEPS - 1)) begin
                    dbusy_reg <= 1'b0;
                    rate_reg  <= {dq_reg[62:0], (dtop || !dtrial[64])};
                end
            end
            if (cmd.mul_start) begin
                macc_reg <= '0;
                mcnt_reg <= '0;
            end else if (cmd.mul_step) begin
                macc_reg <= macc_reg + ({64'd0, mprod} <<
                            (7'(mcnt_reg[1]) * 7'd32 + 7'(mcnt_reg[0]) * 7'd32));
                mcnt_reg <= mcnt_reg + 3'd1;
            end
            if (cmd.ofs_upd) begin
                offset_reg     <= {16'd0, now_reg} - scaled;
                last_ticks_reg <= tick_reg;
                last_ms_reg    <= now_reg;
            end
            if (cmd.tms_calc) begin
                sneg_reg <= (scaled + offset_reg) >> 63 != 0;
                smag_reg <= (((scaled + offset_reg) >> 63) != 0) ?
                            (64'd0 - (scaled + offset_reg)) : (scaled + offset_reg);
                srem_reg <= '0;
                sq_reg   <= '0;
                scnt_reg <= '0;
                fcnt_reg <= '0;
            end
            // even step multiplies, odd step takes the digit and remainder
            if (cmd.sec_step) begin
                if (!scnt_reg[0]) begin
                    sprod_reg <= 52'(sv) * 52'(MS_RECIP);
                end else begin
                    srem_reg <= 10'(sv - 26'(sqd) * 26'(MS_PER_S));
                    sq_reg   <= {sq_reg[15:0], sqd};
                    smag_reg <= smag_reg << 16;
                end
                scnt_reg <= scnt_reg + 4'd1;
            end
            if (cmd.day_calc) begin
                case (fcnt_reg)
                    3'd0: begin
                        ts_reg <= sneg_reg ? (32'd0 - sq_reg) : sq_reg;
                    end
                    3'd1: begin
                        // 86400 = 128 * 675
                        fprod_reg <= 51'(ts_reg[31:7]) * 51'(DAY_RECIP);
                    end
                    3'd2: begin
                        day_reg <= 17'(ts_reg - 32'(fprod_reg[50:35]) * 32'(SEC_PER_DAY));
                    end
                    3'd3: begin
                        // 3600 = 16 * 225
                        fprod_reg <= 51'(day_reg[16:4]) * 51'(HOUR_RECIP);
                    end
                    3'd4: begin
                        hours_reg <= fprod_reg[25:21];
                        rhr_reg   <= 12'(day_reg - 17'(fprod_reg[25:21]) * 17'(SEC_PER_HOUR));
                    end
                    3'd5: begin
                        // 60 = 4 * 15
                        fprod_reg <= 51'(rhr_reg[11:2]) * 51'(MIN_RECIP);
                    end
                    default: begin
                    end
                endcase
                fcnt_reg <= fcnt_reg + 3'd1;
            end
            if (cmd.hms_calc) begin
                min_reg <= fprod_reg[19:14];
                sec_reg <= 6'(rhr_reg - 12'(fprod_reg[19:14]) * 12'(SEC_PER_MIN));
            end
            if (cmd.out_load) begin
                out_ts_reg    <= ts_reg;
                out_hours_reg <= hours_reg;
                out_min_reg   <= min_reg;
                out_sec_reg   <= sec_reg;
            end
        end
    end

    assign sts.is_sync    = kind_reg;
    assign sts.div_needed = (el_ticks != 64'd0);
    assign sts.div_done   = !dbusy_reg;
    assign sts.mul_done   = mcnt_reg[2];
    assign sts.sec_done   = (scnt_reg == 4'(SEC_STEPS));
    assign sts.fold_done  = (fcnt_reg == 3'd6);

    assign time_s  = out_ts_reg;
    assign hours   = out_hours_reg;
    assign minutes = out_min_reg;
    assign seconds = out_sec_reg;

    `CTC_ASSERT_NEXT(a_tick_incr, aclk, aresetn, cmd.load && !in_kind,
                     tick_reg == $past(tick_reg) + 64'd1)
    `CTC_ASSERT_IMP(a_div_bound, aclk, aresetn, dbusy_reg, dcnt_reg < 8'(DIV_STEPS))
    `CTC_ASSERT_IMP(a_mul_bound, aclk, aresetn, cmd.mul_step, !mcnt_reg[2])

endmodule

/* design/calibrated_time_of_day_clock_core.sv */
// Calibrated time-of-day clock core.
// Input stream (s_): one beat is a tick (tuser 0) or a sync carrying a
// millisecond stamp in tdata (tuser 1). A sync sets the rate from ms and
// ticks elapsed since the previous sync and re-anchors the offset.
// Output stream (m_): one beat per input beat, with time in seconds and
// hours/minutes/seconds of the day.
// Path to m_tvalid: rate divider (128 steps, only for a sync with ticks since
// the last one), 4-step multiply, offset update (sync only), 8-step ms->s
// digit loop, 6-step day fold, h/m/s and the output register.
// One beat is worked on at a time; s_tready is high only when idle, so a new
// beat is taken only once the last one has been loaded into the output register.
// Reset: architectural state, counters and output register zero; time reads 0 until the first sync.
// Stall: a finished beat sits in the output register while m_tready is low;
// the core still takes and works on the next input beat, and holds that
// result until the output register is free.
module calibrated_time_of_day_clock_core
    import ctodc_pkg::*;
#(
    parameter int unsigned FRAC_BITS = 32
)(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // now_ms[47:0]
    input  logic        s_tuser,   // kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata    // time_s[31:0], hours[36:32], minutes[42:37],
                                   // seconds[48:43], zero pad
);
    ctodc_cmd_t  cmd;
    ctodc_sts_t  sts;
    logic [31:0] time_s;
    logic [4:0]  hours;
    logic [5:0]  minutes, seconds;

    ctodc_ctrl u_ctrl (
        .aclk, .aresetn, .s_tvalid, .s_tready, .m_tvalid, .m_tready,
        .sts, .cmd
    );

    ctodc_dp #(.FRAC_BITS(FRAC_BITS)) u_dp (
        .aclk, .aresetn, .in_kind(s_tuser), .in_now_ms(s_tdata),
        .cmd, .sts, .time_s, .hours, .minutes, .seconds
    );

    assign m_tdata = {7'd0, seconds, minutes, hours, time_s};

endmodule
